[src/lpe_pkg.sv]
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator package
// Shared constants and the command and status types that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int MAX_ELEMENTS = 12;
  localparam int ELEM_W       = 4;
  localparam int SIZE_W       = 4;
  localparam int RANK_W       = 29;
  localparam int WORD_W       = MAX_ELEMENTS * ELEM_W;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);

  typedef struct packed {
    logic load_ident;
    logic set_pivot;
    logic load_pv;
    logic set_succ;
    logic swap;
    logic rev_read;
    logic rev_write;
    logic capture;
  } lpe_cmd_t;

  typedef struct packed {
    logic fresh;
    logic pivot_found;
    logic rev_more;
  } lpe_stat_t;

endpackage

[src/lpe_datapath.sv]
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator datapath
// Holds the permutation, its rank and the size register, and performs the
// pivot search, swap and suffix reversal under controller commands.
// ----------------------------------------------------------------------------
module lpe_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [lpe_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                        restart,
  input  lpe_pkg::lpe_cmd_t           cmd,
  output lpe_pkg::lpe_stat_t          stat,
  output logic [lpe_pkg::WORD_W-1:0]  perm_word,
  output logic [lpe_pkg::RANK_W-1:0]  seq_index,
  output logic                        last_of_cycle
);
  import lpe_pkg::*;

  logic [ELEM_W-1:0]       perm [MAX_ELEMENTS];
  logic [RANK_W-1:0]       rank;
  logic                    started;
  logic [SIZE_W-1:0]       size;

  logic [IDX_W-1:0]        p;
  logic [IDX_W-1:0]        j;
  logic [IDX_W-1:0]        lo;
  logic [IDX_W-1:0]        hi;
  logic [ELEM_W-1:0]       pv;
  logic [ELEM_W-1:0]       tmp;

  logic [CNT_W-1:0]        n_eff;
  logic [CNT_W-1:0]        n_m1;
  logic [MAX_ELEMENTS-1:0] asc;
  logic [MAX_ELEMENTS-1:0] gt;
  logic [IDX_W-1:0]        pivot_idx;
  logic [IDX_W-1:0]        succ_idx;
  logic [WORD_W-1:0]       word;

  always_comb begin
    if (size == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(size) > CNT_W'(MAX_ELEMENTS)) begin
      n_eff = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_eff = CNT_W'(size);
    end
    n_m1 = n_eff - CNT_W'(1);
  end

  always_comb begin
    asc = '0;
    gt  = '0;
    pivot_idx = '0;
    succ_idx  = '0;
    word = '0;
    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
      asc[i] = (perm[i] < perm[i+1]) && (CNT_W'(i + 1) < n_eff);
    end
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      gt[k] = (perm[k] > pv) && (IDX_W'(k) > p) && (CNT_W'(k) < n_eff);
      if (asc[k]) begin
        pivot_idx = IDX_W'(k);
      end
      if (gt[k]) begin
        succ_idx = IDX_W'(k);
      end
      if (CNT_W'(k) < n_eff) begin
        word[WORD_W-1-ELEM_W*k -: ELEM_W] = perm[k];
      end
    end
  end

  assign stat.fresh       = restart | ~started;
  assign stat.pivot_found = |asc;
  assign stat.rev_more    = lo < hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        perm[i] <= ELEM_W'(i);
      end
      rank    <= '0;
      started <= 1'b0;
      size    <= SIZE_RESET;
    end else begin
      if (cmd.load_ident) begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          perm[i] <= ELEM_W'(i);
        end
        rank <= '0;
      end
      if (cmd.swap) begin
        perm[p] <= perm[j];
        perm[j] <= pv;
        rank    <= rank + RANK_W'(1);
      end
      if (cmd.rev_write) begin
        perm[lo] <= perm[hi];
        perm[hi] <= tmp;
      end
      if (cmd.capture) begin
        started <= 1'b1;
      end
      if (cfg_wen) begin
        size    <= cfg_wdata;
        started <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_pivot) begin
      p <= pivot_idx;
    end
    if (cmd.load_pv) begin
      pv <= perm[p];
    end
    if (cmd.set_succ) begin
      j <= succ_idx;
    end
    if (cmd.swap) begin
      lo <= p + IDX_W'(1);
      hi <= n_m1[IDX_W-1:0];
    end
    if (cmd.rev_read) begin
      tmp <= perm[lo];
    end
    if (cmd.rev_write) begin
      lo <= lo + IDX_W'(1);
      hi <= hi - IDX_W'(1);
    end
    if (cmd.capture) begin
      perm_word     <= word;
      seq_index     <= rank;
      last_of_cycle <= ~(|asc);
    end
  end

endmodule

[src/lpe_ctrl.sv]
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator controller
// Sequences each request through pivot search, swap and suffix reversal, or
// loads the identity on a fresh start or a wrap, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module lpe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  lpe_pkg::lpe_stat_t stat,
  output lpe_pkg::lpe_cmd_t  cmd
);
  import lpe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_LOAD_PV,
    ST_SUCC,
    ST_SWAP,
    ST_REV_RD,
    ST_REV_WR,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (stat.fresh) begin
            cmd.load_ident = 1'b1;
            state_next     = ST_FINISH;
          end else begin
            state_next = ST_PIVOT;
          end
        end
      end
      ST_PIVOT: begin
        if (stat.pivot_found) begin
          cmd.set_pivot = 1'b1;
          state_next    = ST_LOAD_PV;
        end else begin
          cmd.load_ident = 1'b1;
          state_next     = ST_FINISH;
        end
      end
      ST_LOAD_PV: begin
        cmd.load_pv = 1'b1;
        state_next  = ST_SUCC;
      end
      ST_SUCC: begin
        cmd.set_succ = 1'b1;
        state_next   = ST_SWAP;
      end
      ST_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = ST_REV_RD;
      end
      ST_REV_RD: begin
        if (stat.rev_more) begin
          cmd.rev_read = 1'b1;
          state_next   = ST_REV_WR;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_REV_WR: begin
        cmd.rev_write = 1'b1;
        state_next    = ST_REV_RD;
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[src/lexicographic_permutation_enumerator.sv]
// Each request returns the next permutation of 0..n-1 in lexicographic order,
// or the identity on a restart, on the first request after reset or a size
// write, and after the final descending permutation. A restart, or the first
// request after reset or a size write, goes from acceptance straight to the
// capture, and the wrap after the final descending permutation passes the
// pivot search first. Any other request steps through pivot search, pivot
// value load, successor search, swap and suffix reversal. The reversal swaps
// one element pair at a time for the suffix after the pivot, reading the lower
// element into a holding register and then writing the pair. A held-off
// result delays the capture until the output register is free. A new request
// is taken as soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator
// Top level joining the sequencing controller and the permutation datapath.
// ----------------------------------------------------------------------------
module lexicographic_permutation_enumerator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [lpe_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        restart,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [lpe_pkg::WORD_W-1:0]  perm_word,
  output logic [lpe_pkg::RANK_W-1:0]  seq_index,
  output logic                        last_of_cycle
);
  import lpe_pkg::*;

  lpe_cmd_t  cmd;
  lpe_stat_t stat;

  lpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .restart       (restart),
    .cmd           (cmd),
    .stat          (stat),
    .perm_word     (perm_word),
    .seq_index     (seq_index),
    .last_of_cycle (last_of_cycle)
  );

endmodule
